// ===== rtl/nlvt_pkg.sv =====
// Shared types, constants and helpers for the nearest linked value table.
// Used by nlvt_front, nlvt_back and nearest_linked_value_table_top.
package nlvt_pkg;

   // Table capacity and derived widths
   localparam int MAX_LINKS = 256;
   localparam int CNT_W     = $clog2(MAX_LINKS + 1);
   localparam int IDX_W     = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

   // Queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // Command codes
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Result status codes
   localparam logic [1:0] STAT_QUERY  = 2'd0;
   localparam logic [1:0] STAT_STORED = 2'd1;
   localparam logic [1:0] STAT_DUP    = 2'd2;
   localparam logic [1:0] STAT_FULL   = 2'd3;

   // One request beat
   typedef struct packed {
      logic               command;
      logic signed [31:0] start_req;
      logic signed [31:0] finish;
   } item_type;

   // Exact magnitude of the difference of two signed 32-bit values
   function automatic logic [31:0] gap(input logic signed [31:0] x,
                                       input logic signed [31:0] y);
      logic signed [32:0] diff;
      logic        [32:0] mag;
      diff = {x[31], x} - {y[31], y};
      mag  = diff[32] ? (33'd0 - diff) : diff;
      return mag[31:0];
   endfunction

endpackage

// ===== rtl/nlvt_front.sv =====
// Front end: accepts request beats and holds them in a short queue.
// Depends on nlvt_pkg for the item type and queue depth.
module nlvt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_command,
   input  logic signed [31:0]   req_start_req,
   input  logic signed [31:0]   req_finish,
   output nlvt_pkg::item_type   q_item,
   output logic                 q_valid,
   input  logic                 q_pop
);
   import nlvt_pkg::*;

   item_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                push;
   logic                pop;

   // Handshake
   assign busy    = (cnt_ff == QCNT_W'(QDEPTH));
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != '0);
   assign pop     = q_pop && q_valid;
   assign q_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].command   <= req_command;
         slot_ff[wr_ptr_ff].start_req <= req_start_req;
         slot_ff[wr_ptr_ff].finish    <= req_finish;
      end
   end

endmodule

// ===== rtl/nlvt_back.sv =====
// Back end: link memories, scan engine and result register.
// Depends on nlvt_pkg for the item type, codes, widths and gap().
module nlvt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  nlvt_pkg::item_type   q_item,
   input  logic                 q_valid,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_distance,
   output logic [1:0]           rsp_status
);
   import nlvt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Link storage
   logic signed [31:0] link_a_mem [MAX_LINKS];
   logic signed [31:0] link_b_mem [MAX_LINKS];

   state_type          state_ff, state_in;
   item_type           cur_ff;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               p1_ff, p1_in;
   logic               p2_ff;
   logic signed [31:0] rd_a_ff, rd_b_ff;
   logic [31:0]        gap_a_ff, gap_b_ff;
   logic               hit_a_ff, hit_b_ff;
   logic               dup_ff;
   logic [31:0]        best_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_distance_ff;
   logic [1:0]         rsp_status_ff;
   logic               more;
   logic               wr_en;
   logic               is_full;
   logic               dup_hit;
   logic [31:0]        best_ab;

   assign more    = (idx_ff < count_ff);
   assign is_full = (count_ff == CNT_W'(MAX_LINKS));
   assign q_pop   = (state_ff == ST_IDLE) && q_valid;
   assign wr_en   = (state_ff == ST_DONE) && (cur_ff.command == CMD_ADD)
                    && !dup_ff && !is_full;

   // Pair match in either order
   assign dup_hit = ((rd_a_ff == cur_ff.start_req) && (rd_b_ff == cur_ff.finish)) ||
                    ((rd_a_ff == cur_ff.finish) && (rd_b_ff == cur_ff.start_req));

   // Control sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      p1_in    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (q_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (more) begin
               idx_in = idx_ff + 1'b1;
               p1_in  = 1'b1;
            end else if (!p1_ff && !p2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            if (wr_en) begin
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         p1_ff        <= p1_in;
         p2_ff        <= p1_ff;
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   // Memory: one read per cycle, write on a stored link
   always_ff @(posedge clock) begin
      rd_a_ff <= link_a_mem[idx_ff[IDX_W-1:0]];
      rd_b_ff <= link_b_mem[idx_ff[IDX_W-1:0]];
      if (wr_en) begin
         link_a_mem[count_ff[IDX_W-1:0]] <= cur_ff.start_req;
         link_b_mem[count_ff[IDX_W-1:0]] <= cur_ff.finish;
      end
   end

   // Candidate gaps from the beat just read
   always_ff @(posedge clock) begin
      gap_a_ff <= gap(cur_ff.finish, rd_b_ff);
      gap_b_ff <= gap(cur_ff.finish, rd_a_ff);
      hit_a_ff <= p1_ff && (cur_ff.command == CMD_QUERY) && (rd_a_ff == cur_ff.start_req);
      hit_b_ff <= p1_ff && (cur_ff.command == CMD_QUERY) && (rd_b_ff == cur_ff.start_req);
   end

   // Lesser of the running best and the candidates that hit
   always_comb begin
      best_ab = best_ff;
      if (hit_a_ff && (gap_a_ff < best_ab)) begin
         best_ab = gap_a_ff;
      end
      if (hit_b_ff && (gap_b_ff < best_ab)) begin
         best_ab = gap_b_ff;
      end
   end

   // Item capture, running minimum and duplicate flag
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff  <= q_item;
         best_ff <= gap(q_item.start_req, q_item.finish);
         dup_ff  <= 1'b0;
      end else begin
         if (p2_ff) begin
            best_ff <= best_ab;
         end
         if (p1_ff && (cur_ff.command == CMD_ADD) && dup_hit) begin
            dup_ff <= 1'b1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         if (cur_ff.command == CMD_QUERY) begin
            rsp_distance_ff <= best_ff;
            rsp_status_ff   <= STAT_QUERY;
         end else begin
            rsp_distance_ff <= '0;
            if (dup_ff) begin
               rsp_status_ff <= STAT_DUP;
            end else if (is_full) begin
               rsp_status_ff <= STAT_FULL;
            end else begin
               rsp_status_ff <= STAT_STORED;
            end
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== rtl/nearest_linked_value_table_top.sv =====
// Each accepted item waits in the queue, then is scanned against the N stored links
// (N = 0 to 256); the result register is loaded in the done state.
// The back end takes a new item only when idle; the scan of the link memory reads
// one entry per cycle, and a two-beat queue takes new items during a scan.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous, active high) empties the queue and the table; the link
// memory is not cleared, entries beyond the link count are never used.
module nearest_linked_value_table_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic signed [31:0]  req_start_req,
   input  logic signed [31:0]  req_finish,
   output logic                rsp_valid,
   output logic [31:0]         rsp_distance,
   output logic [1:0]          rsp_status
);
   import nlvt_pkg::*;

   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   nlvt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_start_req (req_start_req),
      .req_finish    (req_finish),
      .q_item        (q_item),
      .q_valid       (q_valid),
      .q_pop         (q_pop)
   );

   nlvt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_item       (q_item),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_distance (rsp_distance),
      .rsp_status   (rsp_status)
   );

endmodule
